/* rtl/ofr_pkg.sv */
package ofr_pkg;

  // Primary axis selection carried with every word
  typedef enum logic [1:0] {
    MODE_X   = 2'd0,
    MODE_Y   = 2'd1,
    MODE_Z   = 2'd2,
    MODE_BAD = 2'd3
  } mode_e;

  // Q1.14 unit length
  localparam int unsigned UNIT_ONE = 16384;

  // Classified word handed from the front end to the back end
  typedef struct packed {
    mode_e             mode;
    logic [2:0][15:0]  prim;
    logic [2:0][15:0]  other;
  } job_t;

  // Finished frame: index 0 is the x component, 2 the z component
  typedef struct packed {
    logic [2:0][15:0]  xaxis;
    logic [2:0][15:0]  yaxis;
    logic [2:0][15:0]  zaxis;
    logic              degenerate;
  } res_t;

endpackage

/* rtl/ofr_front.sv */
module ofr_front
  import ofr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] first_x_i,
  input  logic [15:0] first_y_i,
  input  logic [15:0] first_z_i,
  input  logic [15:0] second_x_i,
  input  logic [15:0] second_y_i,
  input  logic [15:0] second_z_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        full_i
);

  logic  job_valid_q, job_valid_d;
  job_t  job_q, job_d;
  logic  take;
  mode_e mode;

  assign in_stall_o = job_valid_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = job_valid_q && !full_i;
  assign job_o      = job_q;
  assign mode       = mode_e'(req_type_i);

  // Pick the vector that is normalized first and the one crossed with it
  always_comb begin
    job_d.mode = mode;
    unique case (mode)
      MODE_X: begin
        job_d.prim  = {first_z_i, first_y_i, first_x_i};
        job_d.other = {second_z_i, second_y_i, second_x_i};
      end
      MODE_Y, MODE_Z: begin
        job_d.prim  = {second_z_i, second_y_i, second_x_i};
        job_d.other = {first_z_i, first_y_i, first_x_i};
      end
      MODE_BAD: begin
        job_d.prim  = '0;
        job_d.other = '0;
      end
    endcase
  end

  // Hold the word until the queue takes it
  assign job_valid_d = take || (job_valid_q && full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_d;
    end
  end

endmodule

/* rtl/ofr_fifo.sv */
module ofr_fifo #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue read while empty");

endmodule

/* rtl/ofr_norm.sv */
module ofr_norm
  import ofr_pkg::*;
#(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2:0][31:0]  vec_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [2:0][15:0]  vec_o,
  output logic              zero_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned ROOT_N = 31;
  localparam int unsigned DIV_N  = 15;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              zero;
    logic [2:0]        neg;
  } tag_t;

  // Magnitude, max and normalizing shift
  logic [2:0][30:0] abs_c, shf_c;
  logic [2:0]       neg_c;
  logic [30:0]      max_c, mm_c;
  logic [4:0]       sh_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = vec_i[i][31];
      abs_c[i] = neg_c[i] ? 31'(~vec_i[i] + 32'd1) : vec_i[i][30:0];
    end
    max_c = abs_c[0];
    if (abs_c[1] > max_c) max_c = abs_c[1];
    if (abs_c[2] > max_c) max_c = abs_c[2];
    mm_c = max_c;
    sh_c = '0;
    if (mm_c[30:14] == '0) begin
      mm_c = mm_c << 16;
      sh_c = sh_c | 5'd16;
    end
    if (mm_c[30:22] == '0) begin
      mm_c = mm_c << 8;
      sh_c = sh_c | 5'd8;
    end
    if (mm_c[30:26] == '0) begin
      mm_c = mm_c << 4;
      sh_c = sh_c | 5'd4;
    end
    if (mm_c[30:28] == '0) begin
      mm_c = mm_c << 2;
      sh_c = sh_c | 5'd2;
    end
    if (mm_c[30:29] == '0) begin
      sh_c = sh_c | 5'd1;
    end
    for (int i = 0; i < 3; i++) begin
      shf_c[i] = abs_c[i] << sh_c;
    end
  end

  logic             s0_valid_q, s1_valid_q;
  tag_t             s0_tag_q, s1_tag_q;
  logic [2:0][30:0] s0_mag_q, s1_mag_q;
  logic [2:0][61:0] s1_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s0_valid_q <= valid_i;
      s1_valid_q <= s0_valid_q;
    end
  end

  // Register shifted magnitudes, then squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_tag_q <= '{side: side_i, zero: (max_c == '0), neg: neg_c};
      s0_mag_q <= shf_c;
      s1_tag_q <= s0_tag_q;
      s1_mag_q <= s0_mag_q;
      for (int i = 0; i < 3; i++) begin
        s1_sq_q[i] <= {31'd0, s0_mag_q[i]} * {31'd0, s0_mag_q[i]};
      end
    end
  end

  // Square root, one result bit per stage
  logic             rt_valid_q [ROOT_N+1];
  logic [61:0]      rt_s_q     [ROOT_N+1];
  logic [61:0]      rt_r_q     [ROOT_N+1];
  logic [2:0][30:0] rt_mag_q   [ROOT_N+1];
  tag_t             rt_tag_q   [ROOT_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_valid_q[0] <= 1'b0;
    end else if (en_i) begin
      rt_valid_q[0] <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_s_q[0]   <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
      rt_r_q[0]   <= '0;
      rt_mag_q[0] <= s1_mag_q;
      rt_tag_q[0] <= s1_tag_q;
    end
  end

  for (genvar k = 0; k < ROOT_N; k++) begin : g_root
    localparam logic [62:0] BIT = 63'd1 << (60 - 2 * k);
    logic [62:0] trial;
    logic        fits;

    assign trial = {1'b0, rt_r_q[k]} + BIT;
    assign fits  = ({1'b0, rt_s_q[k]} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        rt_valid_q[k+1] <= rt_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_s_q[k+1]   <= fits ? (rt_s_q[k] - trial[61:0]) : rt_s_q[k];
        rt_r_q[k+1]   <= fits ? ((rt_r_q[k] >> 1) + BIT[61:0]) : (rt_r_q[k] >> 1);
        rt_mag_q[k+1] <= rt_mag_q[k];
        rt_tag_q[k+1] <= rt_tag_q[k];
      end
    end
  end

  // Rounded division by the root, one quotient bit per stage
  logic             dv_valid_q [DIV_N+1];
  logic [2:0][45:0] dv_rem_q   [DIV_N+1];
  logic [2:0][14:0] dv_quo_q   [DIV_N+1];
  logic [30:0]      dv_den_q   [DIV_N+1];
  tag_t             dv_tag_q   [DIV_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_valid_q[0] <= rt_valid_q[ROOT_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= {1'b0, rt_mag_q[ROOT_N][i], 14'd0}
                        + {16'd0, rt_r_q[ROOT_N][30:1]};
      end
      dv_quo_q[0] <= '0;
      dv_den_q[0] <= rt_r_q[ROOT_N][30:0];
      dv_tag_q[0] <= rt_tag_q[ROOT_N];
    end
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    localparam int unsigned J = DIV_N - 1 - k;
    logic [45:0]      trial;
    logic [2:0][45:0] rem_d;
    logic [2:0][14:0] quo_d;

    assign trial = {15'd0, dv_den_q[k]} << J;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_q[k][i] >= trial) begin
          rem_d[i] = dv_rem_q[k][i] - trial;
          quo_d[i] = dv_quo_q[k][i] | (15'd1 << J);
        end else begin
          rem_d[i] = dv_rem_q[k][i];
          quo_d[i] = dv_quo_q[k][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_valid_q[k+1] <= dv_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[k+1] <= rem_d;
        dv_quo_q[k+1] <= quo_d;
        dv_den_q[k+1] <= dv_den_q[k];
        dv_tag_q[k+1] <= dv_tag_q[k];
      end
    end
  end

  // Clamp, restore sign, zero the output for zero-length vectors
  logic [2:0][15:0] vec_d;
  logic [14:0]      qc;
  logic [15:0]      q16;
  tag_t             tag_l;

  assign tag_l = dv_tag_q[DIV_N];

  always_comb begin
    qc  = '0;
    q16 = '0;
    for (int i = 0; i < 3; i++) begin
      qc  = (dv_quo_q[DIV_N][i] > 15'(UNIT_ONE)) ? 15'(UNIT_ONE) : dv_quo_q[DIV_N][i];
      q16 = {1'b0, qc};
      if (tag_l.zero) begin
        vec_d[i] = '0;
      end else begin
        vec_d[i] = tag_l.neg[i] ? (16'd0 - q16) : q16;
      end
    end
  end

  logic             out_valid_q;
  logic [2:0][15:0] out_vec_q;
  tag_t             out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= dv_valid_q[DIV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_vec_q <= vec_d;
      out_tag_q <= tag_l;
    end
  end

  assign valid_o = out_valid_q;
  assign vec_o   = out_vec_q;
  assign zero_o  = out_tag_q.zero;
  assign side_o  = out_tag_q.side;

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_o |-> vec_o == '0) else $error("zero vector not cleared");
  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !zero_o |-> vec_o != '0) else $error("normalized vector lost");

endmodule

/* rtl/ofr_back.sv */
module ofr_back
  import ofr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

  typedef struct packed {
    mode_e            mode;
    logic [2:0][15:0] other;
  } side1_t;

  typedef struct packed {
    mode_e            mode;
    logic [2:0][15:0] n1;
    logic             zero1;
  } side2_t;

  function automatic logic signed [31:0] smul16(input logic [15:0] a, input logic [15:0] b);
    logic signed [31:0] aw, bw;
    aw = 32'($signed(a));
    bw = 32'($signed(b));
    return aw * bw;
  endfunction

  logic en;
  logic out_valid_q;
  res_t res_q;

  // Whole pipe moves unless the output word is held
  assign en          = !(out_valid_q && out_stall_i);
  assign pop_o       = job_valid_i && en;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // First normalization
  logic [2:0][31:0] n1_in;
  side1_t           s1_in, s1_out;
  logic             n1_valid, n1_zero;
  logic [2:0][15:0] n1_vec;
  logic [$bits(side1_t)-1:0] s1_bits;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_in[i] = {{16{job_i.prim[i][15]}}, job_i.prim[i]};
    end
  end
  assign s1_in  = '{mode: job_i.mode, other: job_i.other};
  assign s1_out = side1_t'(s1_bits);

  ofr_norm #(.SIDE_W($bits(side1_t))) u_norm1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pop_o),
    .vec_i   (n1_in),
    .side_i  (s1_in),
    .valid_o (n1_valid),
    .vec_o   (n1_vec),
    .zero_o  (n1_zero),
    .side_o  (s1_bits)
  );

  // Exact cross product with the input vector
  logic             ca_valid_q, cb_valid_q;
  logic [2:0][31:0] ca_pa_q, ca_pb_q, cb_t_q;
  side2_t           ca_side_q, cb_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_valid_q <= 1'b0;
      cb_valid_q <= 1'b0;
    end else if (en) begin
      ca_valid_q <= n1_valid;
      cb_valid_q <= ca_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ca_pa_q[0] <= smul16(n1_vec[1], s1_out.other[2]);
      ca_pb_q[0] <= smul16(n1_vec[2], s1_out.other[1]);
      ca_pa_q[1] <= smul16(n1_vec[2], s1_out.other[0]);
      ca_pb_q[1] <= smul16(n1_vec[0], s1_out.other[2]);
      ca_pa_q[2] <= smul16(n1_vec[0], s1_out.other[1]);
      ca_pb_q[2] <= smul16(n1_vec[1], s1_out.other[0]);
      ca_side_q  <= '{mode: s1_out.mode, n1: n1_vec, zero1: n1_zero};
      for (int i = 0; i < 3; i++) begin
        cb_t_q[i] <= (ca_side_q.mode == MODE_X) ? (ca_pa_q[i] - ca_pb_q[i])
                                                : (ca_pb_q[i] - ca_pa_q[i]);
      end
      cb_side_q <= ca_side_q;
    end
  end

  // Second normalization
  logic             n2_valid, n2_zero;
  logic [2:0][15:0] n2_vec;
  side2_t           s2_out;
  logic [$bits(side2_t)-1:0] s2_bits;

  assign s2_out = side2_t'(s2_bits);

  ofr_norm #(.SIDE_W($bits(side2_t))) u_norm2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cb_valid_q),
    .vec_i   (cb_t_q),
    .side_i  (cb_side_q),
    .valid_o (n2_valid),
    .vec_o   (n2_vec),
    .zero_o  (n2_zero),
    .side_o  (s2_bits)
  );

  // Unit cross product, products first
  logic [2:0][15:0] cu, cv;
  logic             p_valid_q, p_deg_q;
  logic [2:0][31:0] p_pa_q, p_pb_q;
  mode_e            p_mode_q;
  logic [2:0][15:0] p_n1_q, p_n2_q;

  assign cu = (s2_out.mode == MODE_X) ? n2_vec : s2_out.n1;
  assign cv = (s2_out.mode == MODE_X) ? s2_out.n1 : n2_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= n2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_pa_q[0] <= smul16(cu[1], cv[2]);
      p_pb_q[0] <= smul16(cu[2], cv[1]);
      p_pa_q[1] <= smul16(cu[2], cv[0]);
      p_pb_q[1] <= smul16(cu[0], cv[2]);
      p_pa_q[2] <= smul16(cu[0], cv[1]);
      p_pb_q[2] <= smul16(cu[1], cv[0]);
      p_mode_q  <= s2_out.mode;
      p_n1_q    <= s2_out.n1;
      p_n2_q    <= n2_vec;
      p_deg_q   <= s2_out.zero1 || n2_zero;
    end
  end

  // Round, saturate and place the rows
  logic [2:0][15:0] c_vec;
  logic [31:0]      c_diff, c_mag;
  logic [17:0]      c_rnd;
  logic [15:0]      c_sat;
  res_t             res_d;

  always_comb begin
    c_diff = '0;
    c_mag  = '0;
    c_rnd  = '0;
    c_sat  = '0;
    for (int i = 0; i < 3; i++) begin
      c_diff   = p_pa_q[i] - p_pb_q[i];
      c_mag    = c_diff[31] ? (32'd0 - c_diff) : c_diff;
      c_rnd    = 18'((c_mag + 32'd8192) >> 14);
      c_sat    = (c_rnd > 18'(UNIT_ONE)) ? 16'(UNIT_ONE) : c_rnd[15:0];
      c_vec[i] = c_diff[31] ? (16'd0 - c_sat) : c_sat;
    end
    res_d.degenerate = p_deg_q;
    unique case (p_mode_q)
      MODE_X: begin
        res_d.xaxis = p_n1_q;
        res_d.yaxis = c_vec;
        res_d.zaxis = p_n2_q;
      end
      MODE_Y: begin
        res_d.xaxis = c_vec;
        res_d.yaxis = p_n1_q;
        res_d.zaxis = p_n2_q;
      end
      MODE_Z: begin
        res_d.xaxis = p_n2_q;
        res_d.yaxis = c_vec;
        res_d.zaxis = p_n1_q;
      end
      MODE_BAD: begin
        res_d.xaxis      = '0;
        res_d.yaxis      = '0;
        res_d.zaxis      = '0;
        res_d.degenerate = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  a_frame_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.degenerate |-> res_q.zaxis != '0)
    else $error("frame without z axis");

endmodule

/* rtl/orthonormal_frame_from_two_vectors.sv */
// Throughput: one word per cycle unless a held output word stalls the pipeline; the square root
// (31 stages) and the quotient (15 stages) in each of the two normalizers are fully pipelined.
// A held output word freezes the back pipeline; front register and queue absorb QUEUE_DEPTH + 1.
// Reset (rst_ni low, asynchronous) empties the pipeline and the queue; no other state.
module orthonormal_frame_from_two_vectors
  import ofr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] first_x_i,
  input  logic [15:0] first_y_i,
  input  logic [15:0] first_z_i,
  input  logic [15:0] second_x_i,
  input  logic [15:0] second_y_i,
  input  logic [15:0] second_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] xaxis_x_o,
  output logic [15:0] xaxis_y_o,
  output logic [15:0] xaxis_z_o,
  output logic [15:0] yaxis_x_o,
  output logic [15:0] yaxis_y_o,
  output logic [15:0] yaxis_z_o,
  output logic [15:0] zaxis_x_o,
  output logic [15:0] zaxis_y_o,
  output logic [15:0] zaxis_z_o,
  output logic        degenerate_o
);

  logic push, full, q_valid, pop;
  job_t f_job, q_job;
  logic [$bits(job_t)-1:0] q_data;
  res_t res;

  ofr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .first_z_i  (first_z_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .second_z_i (second_z_i),
    .push_o     (push),
    .job_o      (f_job),
    .full_i     (full)
  );

  ofr_fifo #(.W($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign q_job = job_t'(q_data);

  ofr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign xaxis_x_o    = res.xaxis[0];
  assign xaxis_y_o    = res.xaxis[1];
  assign xaxis_z_o    = res.xaxis[2];
  assign yaxis_x_o    = res.yaxis[0];
  assign yaxis_y_o    = res.yaxis[1];
  assign yaxis_z_o    = res.yaxis[2];
  assign zaxis_x_o    = res.zaxis[0];
  assign zaxis_y_o    = res.zaxis[1];
  assign zaxis_z_o    = res.zaxis[2];
  assign degenerate_o = res.degenerate;

endmodule

/* tb/sv/orthonormal_frame_from_two_vectors_tb.sv */
module orthonormal_frame_from_two_vectors_tb;
  import ofr_pkg::*;

  localparam int NUM_RANDOM = 1000;
  localparam int QUIET_TAIL = 100;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [15:0] first_x_i, first_y_i, first_z_i;
  logic [15:0] second_x_i, second_y_i, second_z_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] xaxis_x_o, xaxis_y_o, xaxis_z_o;
  logic [15:0] yaxis_x_o, yaxis_y_o, yaxis_z_o;
  logic [15:0] zaxis_x_o, zaxis_y_o, zaxis_z_o;
  logic        degenerate_o;

  orthonormal_frame_from_two_vectors dut (.*);

  // One input word with its optional hand-typed frame
  typedef struct {
    mode_e       mode;
    logic [15:0] a [3];
    logic [15:0] b [3];
    bit          typed;
    res_t        frame;
  } vec_pair_t;

  res_t frame_q[$];
  res_t pending_frame;
  int   mismatches;
  int   idle_cycles;
  bit   quiet;

  // Integer square root, floor
  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void cross_exact(input longint u[3], input longint v[3],
                                      output longint c[3]);
    c[0] = u[1] * v[2] - u[2] * v[1];
    c[1] = u[2] * v[0] - u[0] * v[2];
    c[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  // Scale to unit length in Q1.14; return 1 on a zero vector
  function automatic bit unit_vec(input longint v[3], output longint o[3]);
    logic [63:0] mag [3];
    logic [63:0] m, s, r, q;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      o = '{0, 0, 0};
      return 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
    r = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 14) + (r >> 1)) / r;
      if (q > UNIT_ONE) q = UNIT_ONE;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 0;
  endfunction

  // Cross of two unit vectors, rounded back to Q1.14 and saturated
  function automatic void cross_unit_vec(input longint u[3], input longint v[3],
                                         output longint o[3]);
    longint c [3];
    logic [63:0] mag;
    cross_exact(u, v, c);
    for (int i = 0; i < 3; i++) begin
      mag = c[i] < 0 ? -c[i] : c[i];
      mag = (mag + 8192) >> 14;
      if (mag > UNIT_ONE) mag = UNIT_ONE;
      o[i] = c[i] < 0 ? -longint'(mag) : longint'(mag);
    end
  endfunction

  function automatic res_t build_frame(vec_pair_t p);
    longint a [3], b [3], t [3];
    longint x [3], y [3], z [3];
    bit     deg;
    res_t   f;
    x = '{0, 0, 0};
    y = '{0, 0, 0};
    z = '{0, 0, 0};
    deg = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(p.a[i]));
      b[i] = longint'($signed(p.b[i]));
    end
    case (p.mode)
      MODE_X: begin
        deg |= unit_vec(a, x);
        cross_exact(x, b, t);
        deg |= unit_vec(t, z);
        cross_unit_vec(z, x, y);
      end
      MODE_Y: begin
        deg |= unit_vec(b, y);
        cross_exact(a, y, t);
        deg |= unit_vec(t, z);
        cross_unit_vec(y, z, x);
      end
      MODE_Z: begin
        deg |= unit_vec(b, z);
        cross_exact(a, z, t);
        deg |= unit_vec(t, x);
        cross_unit_vec(z, x, y);
      end
      default: deg = 1;
    endcase
    for (int i = 0; i < 3; i++) begin
      f.xaxis[i] = x[i][15:0];
      f.yaxis[i] = y[i][15:0];
      f.zaxis[i] = z[i][15:0];
    end
    f.degenerate = deg;
    return f;
  endfunction

  function automatic res_t frame_of(logic [15:0] xx, xy, xz, yx, yy, yz,
                                    logic [15:0] zx, zy, zz, logic d);
    res_t f;
    f.xaxis = '{xz, xy, xx};
    f.yaxis = '{yz, yy, yx};
    f.zaxis = '{zz, zy, zx};
    f.degenerate = d;
    return f;
  endfunction

  function automatic vec_pair_t pair(mode_e m, int ax, ay, az, bx, by, bz);
    vec_pair_t p;
    p.mode = m;
    p.a = '{ax[15:0], ay[15:0], az[15:0]};
    p.b = '{bx[15:0], by[15:0], bz[15:0]};
    p.typed = 0;
    p.frame = '0;
    return p;
  endfunction

  function automatic vec_pair_t typed_pair(vec_pair_t p, res_t f);
    p.typed = 1;
    p.frame = f;
    return p;
  endfunction

  // Random component: mostly full range, sometimes tiny or at a rail
  function automatic int rand_comp();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 6) - 3;
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      2: return 0;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  function automatic vec_pair_t rand_pair();
    vec_pair_t p;
    int k;
    mode_e m;
    m = mode_e'($urandom_range(0, 19) == 0 ? 3 : $urandom_range(0, 2));
    p = pair(m, rand_comp(), rand_comp(), rand_comp(),
             rand_comp(), rand_comp(), rand_comp());
    // Make the pair parallel now and then
    if ($urandom_range(0, 14) == 0) begin
      k = $urandom_range(0, 1) ? 1 : -1;
      for (int i = 0; i < 3; i++) p.b[i] = 16'(int'($signed(p.a[i])) * k);
    end
    return p;
  endfunction

  // Clock
  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Output-side stall bursts
  initial begin
    out_stall_i = 0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  // Record expected frame on each accepted input word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) frame_q.push_back(pending_frame);
  end

  // Compare each accepted output word against the oldest expected frame
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = frame_of(xaxis_x_o, xaxis_y_o, xaxis_z_o, yaxis_x_o, yaxis_y_o,
                     yaxis_z_o, zaxis_x_o, zaxis_y_o, zaxis_z_o, degenerate_o);
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", got);
      end else begin
        want = frame_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.xaxis[i] !== want.xaxis[i] || got.yaxis[i] !== want.yaxis[i] ||
              got.zaxis[i] !== want.zaxis[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("axis comp %0d: exp x %h y %h z %h, got x %h y %h z %h", i,
                       want.xaxis[i], want.yaxis[i], want.zaxis[i],
                       got.xaxis[i], got.yaxis[i], got.zaxis[i]);
          end
        end
        if (got.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("degenerate: exp %b got %b", want.degenerate, got.degenerate);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else if (in_valid_i || frame_q.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(vec_pair_t p);
    // Random idle burst ahead of the word
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    pending_frame = p.typed ? p.frame : build_frame(p);
    in_valid_i <= 1;
    req_type_i <= p.mode;
    first_x_i  <= p.a[0];
    first_y_i  <= p.a[1];
    first_z_i  <= p.a[2];
    second_x_i <= p.b[0];
    second_y_i <= p.b[1];
    second_z_i <= p.b[2];
    // Hold until accepted
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  vec_pair_t directed [$];

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    quiet = 0;
    in_valid_i = 0;
    req_type_i = MODE_X;
    first_x_i = 0;
    first_y_i = 0;
    first_z_i = 0;
    second_x_i = 0;
    second_y_i = 0;
    second_z_i = 0;
    pending_frame = '0;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Zero vectors, unused mode, identity frames
    directed.push_back(typed_pair(pair(MODE_X, 0, 0, 0, 0, 0, 0),
                       frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)));
    directed.push_back(typed_pair(pair(MODE_Y, 0, 0, 0, 0, 0, 0),
                       frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)));
    directed.push_back(typed_pair(pair(MODE_Z, 0, 0, 0, 0, 0, 0),
                       frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)));
    directed.push_back(typed_pair(pair(MODE_BAD, 4096, 0, 0, 0, 4096, 0),
                       frame_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1)));
    directed.push_back(typed_pair(pair(MODE_X, 4096, 0, 0, 0, 4096, 0),
                       frame_of(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0)));
    directed.push_back(typed_pair(pair(MODE_Z, 0, 4096, 0, 0, 0, 4096),
                       frame_of(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0)));
    directed.push_back(typed_pair(pair(MODE_Y, 4096, 0, 0, 0, 4096, 0),
                       frame_of(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0)));
    // Parallel vectors
    directed.push_back(pair(MODE_X, 100, 200, 300, 200, 400, 600));
    directed.push_back(pair(MODE_Y, 100, -200, 300, -100, 200, -300));
    directed.push_back(pair(MODE_Z, 5, 5, 5, 5, 5, 5));
    // Rails of the input range
    directed.push_back(pair(MODE_X, 32767, 32767, 32767, -32768, -32768, 32767));
    directed.push_back(pair(MODE_Y, -32768, -32768, -32768, 32767, -32768, 32767));
    directed.push_back(pair(MODE_Z, -32768, 32767, 0, -32768, -32768, -32768));
    directed.push_back(pair(MODE_X, -32768, 0, 0, 0, -32768, 0));
    // Tiny vectors, then the unused mode at the rails
    directed.push_back(pair(MODE_X, 1, 0, 0, 0, 1, 0));
    directed.push_back(pair(MODE_Y, -1, 1, 0, 1, 1, 1));
    directed.push_back(pair(MODE_Z, 1, -1, 1, -1, 0, 1));
    directed.push_back(pair(MODE_BAD, -32768, 32767, -1, 1, 0, -32768));

    foreach (directed[i]) send_word(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n >= NUM_RANDOM - QUIET_TAIL) quiet = 1;
      send_word(rand_pair());
    end
    in_valid_i <= 0;

    // Drain
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
